FILE: hw/rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sha1_pkg
// Shared types, constants and round functions for the SHA-1 hash engine.
// ============================================================================
package sha1_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] hash_t;

    localparam int unsigned NumWords  = 5;
    localparam logic [6:0]  LastRound = 7'd79;
    localparam logic [2:0]  LastIdx   = 3'd4;
    localparam logic [5:0]  LastPos   = 6'd63;
    localparam logic [5:0]  LenPos    = 6'd56;
    localparam logic [7:0]  PadMark   = 8'h80;

    localparam hash_t InitHash = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic byte_en;
        logic shift_en;
    } sched_ctl_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [6:0] rnd;
    } round_ctl_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end
        else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end
        else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end
        else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(input logic [6:0] rnd);
        word_t k;
        if (rnd < 7'd20) begin
            k = 32'h5A827999;
        end
        else if (rnd < 7'd40) begin
            k = 32'h6ED9EBA1;
        end
        else if (rnd < 7'd60) begin
            k = 32'h8F1BBCDC;
        end
        else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

FILE: hw/rtl/sha1_hash_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// sha1_hash_engine
// Byte-serial SHA-1 engine with padding and five-word digest output.
// ============================================================================
// One request carries one message byte (has_data) and/or the end mark
// (is_last). Bytes are packed into the block buffer; the 64th byte of a
// block starts the compression, which runs one round per cycle on a single
// shared round unit: the 80 rounds in ST_ROUND, then the chaining add in
// ST_ADD. On the end mark the engine writes the padding bytes one per cycle
// (over one or two blocks), compresses, and then presents digest words A..E
// on the output channel, one per accepted request. in_ready is low while a
// block is compressing, padding or the digest is being delivered.
module sha1_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_data,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha1_pkg::state_t     state_reg, state_next;
    logic [5:0]           pos_reg, pos_next;
    logic [60:0]          cnt_reg, cnt_next;
    logic [6:0]           rnd_reg, rnd_next;
    logic [2:0]           idx_reg, idx_next;
    logic                 pad_reg, pad_next;
    logic                 sent_reg, sent_next;
    logic                 armed_reg, armed_next;
    logic                 fin_reg, fin_next;
    sha1_pkg::hash_t      chain_reg, chain_next;

    sha1_pkg::sched_ctl_t sched_ctl;
    sha1_pkg::round_ctl_t round_ctl;
    logic [7:0]           sbyte;
    logic [7:0]           pad_byte;
    logic [63:0]          len_shift;
    sha1_pkg::word_t      w;
    sha1_pkg::hash_t      wv;

    sha1_sched u_sched (
        .clk  (clk),
        .ctl  (sched_ctl),
        .data (sbyte),
        .w    (w)
    );

    sha1_round u_round (
        .clk   (clk),
        .ctl   (round_ctl),
        .chain (chain_reg),
        .w     (w),
        .wv    (wv)
    );

    assign len_shift = {cnt_reg, 3'b000} << {pos_reg[2:0], 3'b000};

    always_comb
    begin
        if (!sent_reg)
        begin
            pad_byte = sha1_pkg::PadMark;
        end
        else if (armed_reg && (pos_reg >= sha1_pkg::LenPos))
        begin
            pad_byte = len_shift[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        pos_next           = pos_reg;
        cnt_next           = cnt_reg;
        rnd_next           = rnd_reg;
        idx_next           = idx_reg;
        pad_next           = pad_reg;
        sent_next          = sent_reg;
        armed_next         = armed_reg;
        fin_next           = fin_reg;
        chain_next         = chain_reg;
        sched_ctl.byte_en  = 1'b0;
        sched_ctl.shift_en = 1'b0;
        sbyte              = data_byte;
        round_ctl.load     = 1'b0;
        round_ctl.step     = 1'b0;
        round_ctl.rnd      = rnd_reg;

        case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pad_next   = is_last;
                    sent_next  = 1'b0;
                    armed_next = 1'b0;
                    fin_next   = 1'b0;
                    if (has_data)
                    begin
                        sched_ctl.byte_en = 1'b1;
                        pos_next          = pos_reg + 6'd1;
                        cnt_next          = cnt_reg + 61'd1;
                        if (pos_reg == sha1_pkg::LastPos)
                        begin
                            round_ctl.load = 1'b1;
                            state_next     = sha1_pkg::ST_ROUND;
                        end
                        else if (is_last)
                        begin
                            state_next = sha1_pkg::ST_PAD;
                        end
                    end
                    else if (is_last)
                    begin
                        state_next = sha1_pkg::ST_PAD;
                    end
                end
            end

            sha1_pkg::ST_PAD:
            begin
                sched_ctl.byte_en = 1'b1;
                sbyte             = pad_byte;
                pos_next          = pos_reg + 6'd1;
                if (!sent_reg)
                begin
                    sent_next  = 1'b1;
                    armed_next = (pos_reg < sha1_pkg::LenPos);
                end
                if (pos_reg == sha1_pkg::LastPos)
                begin
                    fin_next       = armed_reg && sent_reg;
                    armed_next     = 1'b1;
                    round_ctl.load = 1'b1;
                    state_next     = sha1_pkg::ST_ROUND;
                end
            end

            sha1_pkg::ST_ROUND:
            begin
                round_ctl.step     = 1'b1;
                sched_ctl.shift_en = 1'b1;
                rnd_next           = rnd_reg + 7'd1;
                if (rnd_reg == sha1_pkg::LastRound)
                begin
                    rnd_next   = 7'd0;
                    state_next = sha1_pkg::ST_ADD;
                end
            end

            sha1_pkg::ST_ADD:
            begin
                for (int i = 0; i < sha1_pkg::NumWords; i++)
                begin
                    chain_next[i] = chain_reg[i] + wv[i];
                end
                if (fin_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = sha1_pkg::ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = sha1_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha1_pkg::ST_IDLE;
                end
            end

            sha1_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == sha1_pkg::LastIdx)
                    begin
                        chain_next = sha1_pkg::InitHash;
                        cnt_next   = 61'd0;
                        pos_next   = 6'd0;
                        pad_next   = 1'b0;
                        fin_next   = 1'b0;
                        state_next = sha1_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1_pkg::ST_IDLE;
            pos_reg   <= 6'd0;
            cnt_reg   <= 61'd0;
            rnd_reg   <= 7'd0;
            idx_reg   <= 3'd0;
            pad_reg   <= 1'b0;
            sent_reg  <= 1'b0;
            armed_reg <= 1'b0;
            fin_reg   <= 1'b0;
            chain_reg <= sha1_pkg::InitHash;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            sent_reg  <= sent_next;
            armed_reg <= armed_next;
            fin_reg   <= fin_next;
            chain_reg <= chain_next;
        end
    end

    assign in_ready    = (state_reg == sha1_pkg::ST_IDLE);
    assign out_valid   = (state_reg == sha1_pkg::ST_OUT);
    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == sha1_pkg::LastIdx);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output channels both open");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= sha1_pkg::LastRound)
        else $error("round counter out of range");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::ST_ROUND && rnd_reg == sha1_pkg::LastRound)
        |=> (state_reg == sha1_pkg::ST_ADD && rnd_reg == 7'd0))
        else $error("compression did not end after the last round");

    a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg <= sha1_pkg::LastIdx))
        else $error("digest word index out of range");

endmodule

FILE: hw/rtl/sha1_sched.sv
`timescale 1ns / 1ps
// ============================================================================
// sha1_sched
// 512-bit block buffer: packs bytes big-endian, then expands the message
// schedule in place one word per round.
// ============================================================================
module sha1_sched (
    input  logic                  clk,
    input  sha1_pkg::sched_ctl_t  ctl,
    input  logic [7:0]            data,
    output sha1_pkg::word_t       w
);

    logic [511:0]    blk_reg;
    logic [511:0]    blk_next;
    sha1_pkg::word_t w_new;

    assign w     = blk_reg[511:480];
    assign w_new = sha1_pkg::rotl(blk_reg[95:64] ^ blk_reg[255:224] ^
                                  blk_reg[447:416] ^ blk_reg[511:480], 5'd1);

    always_comb
    begin
        blk_next = blk_reg;
        if (ctl.byte_en)
        begin
            blk_next = {blk_reg[503:0], data};
        end
        else if (ctl.shift_en)
        begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

FILE: hw/rtl/sha1_round.sv
`timescale 1ns / 1ps
// ============================================================================
// sha1_round
// Working registers A..E and the single round datapath used for all 80 rounds.
// ============================================================================
module sha1_round (
    input  logic                  clk,
    input  sha1_pkg::round_ctl_t  ctl,
    input  sha1_pkg::hash_t       chain,
    input  sha1_pkg::word_t       w,
    output sha1_pkg::hash_t       wv
);

    sha1_pkg::hash_t wv_reg;
    sha1_pkg::hash_t wv_next;
    sha1_pkg::word_t t;

    assign t = sha1_pkg::rotl(wv_reg[0], 5'd5)
             + sha1_pkg::round_f(ctl.rnd, wv_reg[1], wv_reg[2], wv_reg[3])
             + wv_reg[4] + sha1_pkg::round_k(ctl.rnd) + w;

    always_comb
    begin
        wv_next = wv_reg;
        if (ctl.load)
        begin
            wv_next = chain;
        end
        else if (ctl.step)
        begin
            wv_next[4] = wv_reg[3];
            wv_next[3] = wv_reg[2];
            wv_next[2] = sha1_pkg::rotl(wv_reg[1], 5'd30);
            wv_next[1] = wv_reg[0];
            wv_next[0] = t;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg <= wv_next;
    end

    assign wv = wv_reg;

endmodule
